@@ hdl/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

   localparam int CP_W       = 21;
   localparam int COUNT_W    = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

   // Lead byte limits and per-lead narrowed second-byte ranges.
   localparam logic [7:0] LEAD_MIN   = 8'hC2;
   localparam logic [7:0] LEAD_MAX   = 8'hF4;
   localparam logic [7:0] TAIL_LO    = 8'h80;
   localparam logic [7:0] TAIL_HI    = 8'hBF;
   localparam logic [7:0] LEAD_E0    = 8'hE0;
   localparam logic [7:0] LO_AFTER_E0 = 8'hA0;
   localparam logic [7:0] LEAD_ED    = 8'hED;
   localparam logic [7:0] HI_AFTER_ED = 8'h9F;
   localparam logic [7:0] LEAD_F0    = 8'hF0;
   localparam logic [7:0] LO_AFTER_F0 = 8'h90;
   localparam logic [7:0] LEAD_F4    = 8'hF4;
   localparam logic [7:0] HI_AFTER_F4 = 8'h8F;
   localparam logic [7:0] MASK_TWO   = 8'hE0;
   localparam logic [7:0] PAT_TWO    = 8'hC0;
   localparam logic [7:0] MASK_THREE = 8'hF0;
   localparam logic [7:0] PAT_THREE  = 8'hE0;

   localparam logic [COUNT_W-1:0] LEN_NONE  = 3'd0;
   localparam logic [COUNT_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] LEN_THREE = 3'd3;
   localparam logic [COUNT_W-1:0] LEN_FOUR  = 3'd4;

   // One classified input: a burst of invalid results, then an optional final result.
   typedef struct packed {
      logic [1:0]         inv_count;
      logic               has_final;
      logic               final_valid;
      logic [COUNT_W-1:0] final_count;
      logic [CP_W-1:0]    final_cp;
   } job_type;

endpackage

@@ hdl/utf8d_front.sv @@
// Front end: accepts bytes, tracks the open sequence and classifies each transaction.
module utf8d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_text,
   output logic              push,
   output utf8d_pkg::job_type job
);
   import utf8d_pkg::*;

   logic [7:0]         lead_ff, lead_in;
   logic [COUNT_W-1:0] exp_len_ff, exp_len_in;
   logic [COUNT_W-1:0] taken_ff, taken_in;
   logic [CP_W-1:0]    partial_ff, partial_in;

   logic               is_ascii;
   logic               is_lead;
   logic [COUNT_W-1:0] lead_len;
   logic [CP_W-1:0]    lead_partial;
   logic [7:0]         tail_lo;
   logic [7:0]         tail_hi;
   logic               tail_ok;
   logic [COUNT_W-1:0] taken_next;
   logic [CP_W-1:0]    partial_next;
   logic               do_lead;

   always_comb begin
      is_ascii = ~data_byte[7];
      is_lead  = (data_byte >= LEAD_MIN) && (data_byte <= LEAD_MAX);
      priority if ((data_byte & MASK_TWO) == PAT_TWO) begin
         lead_len     = LEN_TWO;
         lead_partial = {16'd0, data_byte[4:0]};
      end else if ((data_byte & MASK_THREE) == PAT_THREE) begin
         lead_len     = LEN_THREE;
         lead_partial = {17'd0, data_byte[3:0]};
      end else begin
         lead_len     = LEN_FOUR;
         lead_partial = {18'd0, data_byte[2:0]};
      end
   end

   always_comb begin
      tail_lo = TAIL_LO;
      tail_hi = TAIL_HI;
      if (taken_ff == LEN_ONE) begin
         if (lead_ff == LEAD_E0)      tail_lo = LO_AFTER_E0;
         else if (lead_ff == LEAD_ED) tail_hi = HI_AFTER_ED;
         else if (lead_ff == LEAD_F0) tail_lo = LO_AFTER_F0;
         else if (lead_ff == LEAD_F4) tail_hi = HI_AFTER_F4;
      end
      tail_ok      = (data_byte >= tail_lo) && (data_byte <= tail_hi);
      taken_next   = taken_ff + LEN_ONE;
      partial_next = {partial_ff[CP_W-7:0], data_byte[5:0]};
   end

   always_comb begin
      lead_in    = lead_ff;
      exp_len_in = exp_len_ff;
      taken_in   = taken_ff;
      partial_in = partial_ff;
      job        = '0;
      do_lead    = 1'b0;

      if (accept) begin
         priority if (end_of_text) begin
            if (exp_len_ff != LEN_NONE) begin
               job.inv_count = taken_ff[1:0];
               lead_in    = '0;
               exp_len_in = LEN_NONE;
               taken_in   = '0;
               partial_in = '0;
            end
         end else if (exp_len_ff == LEN_NONE) begin
            do_lead = 1'b1;
         end else if (tail_ok) begin
            if (taken_next >= exp_len_ff) begin
               job.has_final   = 1'b1;
               job.final_valid = 1'b1;
               job.final_count = exp_len_ff;
               job.final_cp    = partial_next;
               lead_in    = '0;
               exp_len_in = LEN_NONE;
               taken_in   = '0;
               partial_in = '0;
            end else begin
               taken_in   = taken_next;
               partial_in = partial_next;
            end
         end else begin
            // Flush what was taken, then retry the failing byte as a lead.
            job.inv_count = taken_ff[1:0];
            lead_in    = '0;
            exp_len_in = LEN_NONE;
            taken_in   = '0;
            partial_in = '0;
            do_lead    = 1'b1;
         end

         if (do_lead) begin
            priority if (is_ascii) begin
               job.has_final   = 1'b1;
               job.final_valid = 1'b1;
               job.final_count = LEN_ONE;
               job.final_cp    = {13'd0, data_byte};
            end else if (is_lead) begin
               lead_in    = data_byte;
               exp_len_in = lead_len;
               taken_in   = LEN_ONE;
               partial_in = lead_partial;
            end else begin
               job.has_final   = 1'b1;
               job.final_valid = 1'b0;
               job.final_count = LEN_ONE;
            end
         end
      end
      push = (job.inv_count != 2'd0) || job.has_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff    <= '0;
         exp_len_ff <= LEN_NONE;
         taken_ff   <= '0;
         partial_ff <= '0;
      end else begin
         lead_ff    <= lead_in;
         exp_len_ff <= exp_len_in;
         taken_ff   <= taken_in;
         partial_ff <= partial_in;
      end
   end

endmodule

@@ hdl/utf8d_queue.sv @@
// Short job queue between the classifier and the result sequencer.
module utf8d_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  utf8d_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output utf8d_pkg::job_type head_job
);
   import utf8d_pkg::*;

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue pop while empty");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("queue pointers disagree with count");
`endif

endmodule

@@ hdl/utf8d_back.sv @@
// Back end: expands queued jobs into result transactions, one per cycle unless the output stalls.
module utf8d_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [utf8d_pkg::CP_W-1:0]    repl_code,
   input  logic                          head_valid,
   input  utf8d_pkg::job_type            head_job,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [utf8d_pkg::CP_W-1:0]    rsp_code_point,
   output logic                          rsp_is_valid,
   output logic [utf8d_pkg::COUNT_W-1:0] rsp_seq_bytes,
   output logic                          rsp_last_of_run
);
   import utf8d_pkg::*;

   logic [1:0]         emitted_ff, emitted_in;
   logic               valid_ff, valid_in;
   logic [CP_W-1:0]    cp_ff, cp_in;
   logic               ok_ff, ok_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               last_ff, last_in;
   logic               load;
   logic               job_done;

   always_comb begin
      load = head_valid && (!valid_ff || !rsp_stall);
      if (emitted_ff != head_job.inv_count) begin
         cp_in    = repl_code;
         ok_in    = 1'b0;
         cnt_in   = LEN_ONE;
         job_done = ((emitted_ff + 2'd1) == head_job.inv_count) && !head_job.has_final;
      end else begin
         cp_in    = head_job.final_valid ? head_job.final_cp : repl_code;
         ok_in    = head_job.final_valid;
         cnt_in   = head_job.final_count;
         job_done = 1'b1;
      end
      last_in = job_done;
      pop     = load && job_done;

      emitted_in = emitted_ff;
      if (load) emitted_in = job_done ? 2'd0 : emitted_ff + 2'd1;

      // Hold a stalled result; otherwise refill from the queue head.
      valid_in = valid_ff;
      if (!valid_ff || !rsp_stall) valid_in = head_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emitted_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         emitted_ff <= emitted_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff   <= cp_in;
         ok_ff   <= ok_in;
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_is_valid    = ok_ff;
   assign rsp_seq_bytes   = cnt_ff;
   assign rsp_last_of_run = last_ff;

`ifndef NO_ASSERTIONS
   a_burst_in_job: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= head_job.inv_count || !head_valid)
      else $error("invalid burst ran past its job");
   a_invalid_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !ok_ff) |-> (cnt_ff == LEN_ONE && cp_ff == repl_code))
      else $error("invalid result not a single replacement byte");
`endif

endmodule

@@ hdl/utf8_stream_decoder.sv @@
// Top level of the strict UTF-8 stream decoder.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  data_byte, end_of_text
//   rsp_      out        rsp_valid / rsp_stall  code_point, is_valid, seq_bytes, last_of_run
//   csr_      in         csr_wr_en              replacement code (21 bits)
//
// One byte is accepted per cycle while not stalled; the classifier updates its sequence state
// in that cycle. Each transaction yields 0 to 4 results, sent by the result sequencer at one
// per cycle while the output is not stalled. Input stalls only when the 4-entry job queue is
// full. The first result of a transaction passes through the job queue and the output register
// before it is valid.
// Reset closes any open sequence, empties the queue and sets the code to U+FFFD.
module utf8_stream_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_end_of_text,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [utf8d_pkg::CP_W-1:0]    rsp_code_point,
   output logic                          rsp_is_valid,
   output logic [utf8d_pkg::COUNT_W-1:0] rsp_seq_bytes,
   output logic                          rsp_last_of_run,
   input  logic                          csr_wr_en,
   input  logic [utf8d_pkg::CP_W-1:0]    csr_wr_data
);
   import utf8d_pkg::*;

   logic [CP_W-1:0] repl_ff, repl_in;
   logic            accept;
   logic            push;
   job_type         push_job;
   logic            pop;
   logic            full;
   logic            not_empty;
   job_type         head_job;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign repl_in   = csr_wr_en ? csr_wr_data : repl_ff;

   always_ff @(posedge clock) begin
      if (reset) repl_ff <= REPL_RESET;
      else       repl_ff <= repl_in;
   end

   utf8d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .end_of_text (req_end_of_text),
      .push        (push),
      .job         (push_job)
   );

   utf8d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   utf8d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .repl_code       (repl_ff),
      .head_valid      (not_empty),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_is_valid    (rsp_is_valid),
      .rsp_seq_bytes   (rsp_seq_bytes),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ verif/utf8_decode_checker.sv @@
// Checker for the UTF-8 stream decoder: tracks decode state, predicts results and compares them.
module utf8_decode_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_end_of_text,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [utf8d_pkg::CP_W-1:0]    rsp_code_point,
   input  logic                          rsp_is_valid,
   input  logic [utf8d_pkg::COUNT_W-1:0] rsp_seq_bytes,
   input  logic                          rsp_last_of_run,
   input  logic                          csr_wr_en,
   input  logic [utf8d_pkg::CP_W-1:0]    csr_wr_data,
   output int                            outstanding,
   output int                            results_seen,
   output int                            fail_count
);
   import utf8d_pkg::*;

   localparam logic [7:0] ASCII_MAX = 8'h7F;

   typedef struct packed {
      logic [CP_W-1:0]    code_point;
      logic               is_valid;
      logic [COUNT_W-1:0] seq_bytes;
      logic               last_of_run;
   } decoded_type;

   decoded_type         expected_q[$];
   logic [CP_W-1:0]     replacement;
   logic [7:0]          seq_lead;
   logic [COUNT_W-1:0]  seq_len;
   logic [COUNT_W-1:0]  seq_taken;
   logic [CP_W-1:0]     seq_value;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic add_result(input logic [CP_W-1:0] cp, input logic ok,
                             input logic [COUNT_W-1:0] count);
      decoded_type r;
      r.code_point  = cp;
      r.is_valid    = ok;
      r.seq_bytes   = count;
      r.last_of_run = 1'b0;
      expected_q.push_back(r);
   endtask

   task automatic close_sequence();
      seq_lead  = '0;
      seq_len   = LEN_NONE;
      seq_taken = LEN_NONE;
      seq_value = '0;
   endtask

   // Give back every byte of the open sequence as one invalid result each.
   task automatic flush_sequence();
      for (int i = 0; i < seq_taken; i++)
         add_result(replacement, 1'b0, LEN_ONE);
      close_sequence();
   endtask

   task automatic open_sequence(input logic [7:0] data);
      if (data <= ASCII_MAX) begin
         add_result(CP_W'(data), 1'b1, LEN_ONE);
      end else if (data >= LEAD_MIN && data <= LEAD_MAX) begin
         seq_lead  = data;
         seq_taken = LEN_ONE;
         if ((data & MASK_TWO) == PAT_TWO) begin
            seq_len   = LEN_TWO;
            seq_value = CP_W'(data[4:0]);
         end else if ((data & MASK_THREE) == PAT_THREE) begin
            seq_len   = LEN_THREE;
            seq_value = CP_W'(data[3:0]);
         end else begin
            seq_len   = LEN_FOUR;
            seq_value = CP_W'(data[2:0]);
         end
      end else begin
         add_result(replacement, 1'b0, LEN_ONE);
      end
   endtask

   // Second byte range narrows after E0, ED, F0 and F4.
   function automatic logic tail_fits(input logic [7:0] data);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = TAIL_LO;
      hi = TAIL_HI;
      if (seq_taken == LEN_ONE) begin
         if (seq_lead == LEAD_E0)      lo = LO_AFTER_E0;
         else if (seq_lead == LEAD_ED) hi = HI_AFTER_ED;
         else if (seq_lead == LEAD_F0) lo = LO_AFTER_F0;
         else if (seq_lead == LEAD_F4) hi = HI_AFTER_F4;
      end
      return data >= lo && data <= hi;
   endfunction

   task automatic predict_item(input logic [7:0] data, input logic eot);
      int          queued_at_start;
      decoded_type final_res;
      queued_at_start = expected_q.size();
      if (eot) begin
         if (seq_len != LEN_NONE) flush_sequence();
      end else if (seq_len == LEN_NONE) begin
         open_sequence(data);
      end else if (tail_fits(data)) begin
         seq_value = {seq_value[CP_W-7:0], data[5:0]};
         seq_taken = seq_taken + LEN_ONE;
         if (seq_taken >= seq_len) begin
            add_result(seq_value, 1'b1, seq_len);
            close_sequence();
         end
      end else begin
         flush_sequence();
         open_sequence(data);
      end
      // Mark the final result of this transaction.
      if (expected_q.size() > queued_at_start) begin
         final_res = expected_q.pop_back();
         final_res.last_of_run = 1'b1;
         expected_q.push_back(final_res);
      end
   endtask

   task automatic check_result();
      decoded_type want;
      results_seen++;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected, code_point %h",
                                   rsp_code_point));
      end else begin
         want = expected_q.pop_front();
         if (rsp_code_point !== want.code_point)
            report_mismatch($sformatf("code_point %h, expected %h",
                                      rsp_code_point, want.code_point));
         if (rsp_is_valid !== want.is_valid)
            report_mismatch($sformatf("is_valid %b, expected %b",
                                      rsp_is_valid, want.is_valid));
         if (rsp_seq_bytes !== want.seq_bytes)
            report_mismatch($sformatf("seq_bytes %0d, expected %0d",
                                      rsp_seq_bytes, want.seq_bytes));
         if (rsp_last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      rsp_last_of_run, want.last_of_run));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         replacement  = REPL_RESET;
         close_sequence();
         expected_q.delete();
         results_seen = 0;
         fail_count   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (csr_wr_en) replacement = csr_wr_data;
         if (req_valid && !req_stall) predict_item(req_data_byte, req_end_of_text);
      end
      outstanding = expected_q.size();
   end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the UTF-8 stream decoder: stimulus, output stalls and verdict.
module tb_top;
   import utf8d_pkg::*;

   localparam int HOLD_OFF_CYCLES  = 80;
   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_LIMIT      = 5000;
   localparam int RANDOM_PER_PHASE = 44;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic [7:0]         req_data_byte   = 8'h00;
   logic               req_end_of_text = 1'b0;
   logic               rsp_stall       = 1'b0;
   logic               csr_wr_en       = 1'b0;
   logic [CP_W-1:0]    csr_wr_data     = '0;
   logic               req_stall;
   logic               rsp_valid;
   logic [CP_W-1:0]    rsp_code_point;
   logic               rsp_is_valid;
   logic [COUNT_W-1:0] rsp_seq_bytes;
   logic               rsp_last_of_run;

   int outstanding;
   int results_seen;
   int fail_count;
   int items_sent    = 0;
   bit burst_mode    = 1'b0;
   bit hold_off_req  = 1'b0;
   bit hold_off_done = 1'b0;

   utf8_stream_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_is_valid    (rsp_is_valid),
      .rsp_seq_bytes   (rsp_seq_bytes),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   utf8_decode_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_is_valid    (rsp_is_valid),
      .rsp_seq_bytes   (rsp_seq_bytes),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .outstanding     (outstanding),
      .results_seen    (results_seen),
      .fail_count      (fail_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly short idles, now and then a long one.
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int code_length(input logic [CP_W-1:0] cp);
      if (cp < 'h80)    return 1;
      if (cp < 'h800)   return 2;
      if (cp < 'h10000) return 3;
      return 4;
   endfunction

   // Random scalar value with the given encoded length; favor the narrowed leads.
   function automatic logic [CP_W-1:0] pick_code(input int length);
      logic [CP_W-1:0] cp;
      int unsigned     pick;
      pick = $urandom_range(0, 3);
      case (length)
         1: cp = CP_W'($urandom_range(0, 'h7F));
         2: cp = CP_W'($urandom_range('h80, 'h7FF));
         3: begin
            if (pick == 0)      cp = CP_W'($urandom_range('h800, 'hFFF));
            else if (pick == 1) cp = CP_W'($urandom_range('hD000, 'hD7FF));
            else begin
               cp = CP_W'($urandom_range('h800, 'hFFFF));
               // move out of the surrogate block
               if (cp[15:11] == 5'b11011) cp[12] = 1'b0;
            end
         end
         default: begin
            if (pick == 0)      cp = CP_W'($urandom_range('h10000, 'h3FFFF));
            else if (pick == 1) cp = CP_W'($urandom_range('h100000, 'h10FFFF));
            else                cp = CP_W'($urandom_range('h10000, 'h10FFFF));
         end
      endcase
      return cp;
   endfunction

   task automatic send_item(input logic [7:0] data, input logic eot);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Send the first keep bytes of the encoding of cp.
   task automatic send_prefix(input logic [CP_W-1:0] cp, input int keep);
      logic [7:0] enc [0:3];
      int         len;
      len = code_length(cp);
      case (len)
         1: enc[0] = cp[7:0];
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < len && i < keep; i++)
         send_item(enc[i], 1'b0);
   endtask

   task automatic send_random_unit();
      int unsigned     r;
      logic [CP_W-1:0] cp;
      logic [7:0]      lead;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         send_prefix(pick_code($urandom_range(1, 4)), 4);
      end else if (r < 72) begin
         // cut a sequence short, then end the text or break it with any byte
         cp = pick_code($urandom_range(2, 4));
         send_prefix(cp, $urandom_range(1, code_length(cp) - 1));
         if ($urandom_range(0, 1)) send_item(8'($urandom_range(0, 255)), 1'b1);
         else                      send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 82) begin
         case ($urandom_range(0, 4))
            0:       lead = LEAD_E0;
            1:       lead = LEAD_ED;
            2:       lead = LEAD_F0;
            3:       lead = LEAD_F4;
            default: lead = 8'($urandom_range(LEAD_MIN, LEAD_MAX));
         endcase
         send_item(lead, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 94) begin
         send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic send_random_text(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) send_random_unit();
   endtask

   // Drop valid, drain all expected results, then let the pipeline empty.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_replacement(input logic [CP_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Output side: free runs, short and long stalls, one long hold-off on request.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("run timed out");
      $display("FAIL utf8_stream_decoder");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // boundary values of each encoded length, default replacement code
      send_prefix(21'h000000, 4);
      send_prefix(21'h00007F, 4);
      send_prefix(21'h000080, 4);
      send_prefix(21'h0007FF, 4);
      send_prefix(21'h000800, 4);
      send_prefix(21'h10FFFF, 4);
      // bytes that can never start a sequence
      send_item(8'h80, 1'b0);
      send_item(8'hC1, 1'b0);
      send_item(8'hF5, 1'b0);
      send_item(8'hFF, 1'b0);
      // overlong after E0, surrogate after ED
      send_item(LEAD_E0, 1'b0);
      send_item(8'h9F, 1'b0);
      send_item(LEAD_ED, 1'b0);
      send_item(8'hA0, 1'b0);
      // three bytes taken, then a break that starts a new character
      send_item(LEAD_F0, 1'b0);
      send_item(8'h90, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h41, 1'b0);
      // end of text inside a sequence, then with nothing open
      send_item(8'hC2, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      wait_idle();

      write_replacement(21'h10FFFF);
      send_random_text(RANDOM_PER_PHASE);
      wait_idle();

      write_replacement(21'h000000);
      send_random_text(RANDOM_PER_PHASE);
      wait_idle();

      write_replacement(21'h0FFFFF);
      send_random_text(RANDOM_PER_PHASE / 2);
      // keep offering back to back while the output is held off
      burst_mode   = 1'b1;
      hold_off_req = 1'b1;
      while (!hold_off_done) send_random_unit();
      burst_mode = 1'b0;
      send_random_text(RANDOM_PER_PHASE / 2);
      wait_idle();

      write_replacement(CP_W'($urandom_range(0, 'h10FFFF)));
      send_random_text(RANDOM_PER_PHASE);
      wait_idle();

      $display("Sent %0d bytes and end-of-text marks, checked %0d results", items_sent,
               results_seen);
      $display("Covered five replacement codes, error bursts and a full-queue input stall");
      if (outstanding != 0)
         $display("%0d expected results never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS utf8_stream_decoder");
      else
         $display("FAIL utf8_stream_decoder");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/utf8d_pkg.sv
hdl/utf8d_front.sv
hdl/utf8d_queue.sv
hdl/utf8d_back.sv
hdl/utf8_stream_decoder.sv
verif/utf8_decode_checker.sv
verif/tb_top.sv
